FILE: design/kcl_pkg.sv
//------------------------------------------------------------------------------
// kcl_pkg
// Shared widths, codes and types of the canonical k-mer count lookup.
//------------------------------------------------------------------------------
`default_nettype none

package kcl_pkg;

  localparam int WORD_W     = 64;
  localparam int FREQ_W     = 32;
  localparam int INDEX_W    = 12;
  localparam int LEN_W      = 6;
  localparam int COUNT_W    = 13;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int MAX_BASES  = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WORD_LENGTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

  // Request actions.
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  localparam logic [LEN_W-1:0]   WORD_LENGTH_RST = 6'd16;
  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 13'd0;

  typedef logic [WORD_W-1:0] kmer_t;
  typedef logic [FREQ_W-1:0] freq_t;

  // Write side of the table memories; the address travels beside it.
  typedef struct packed {
    logic  en;
    kmer_t word;
    freq_t freq;
  } kcl_wr_t;

endpackage

`default_nettype wire

FILE: design/kcl_if.sv
//------------------------------------------------------------------------------
// kcl_if
// Request and result channels of the canonical k-mer count lookup.
//------------------------------------------------------------------------------
`default_nettype none

interface kcl_req_if;
  logic                             valid;
  logic                             ready;
  logic                             action;
  logic [kcl_pkg::INDEX_W-1:0]      entry_index;
  kcl_pkg::kmer_t                   kmer_word;
  kcl_pkg::freq_t                   load_frequency;

  modport source (output valid, action, entry_index, kmer_word, load_frequency,
                  input ready);
  modport sink (input valid, action, entry_index, kmer_word, load_frequency,
                output ready);
endinterface

interface kcl_rsp_if;
  logic           valid;
  logic           ready;
  kcl_pkg::freq_t frequency;

  modport source (output valid, frequency, input ready);
  modport sink (input valid, frequency, output ready);
endinterface

`default_nettype wire

FILE: design/kcl_canon.sv
//------------------------------------------------------------------------------
// kcl_canon
// Reverse complement of a packed k-mer over a programmable number of bases.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_canon (
  input  wire kcl_pkg::kmer_t               word,
  input  wire logic [kcl_pkg::LEN_W-1:0]    word_length,
  output kcl_pkg::kmer_t                    rc
);

  kcl_pkg::kmer_t                  rc_full;
  logic [kcl_pkg::LEN_W-1:0]       bases;
  logic [kcl_pkg::LEN_W-1:0]       unused_bases;
  logic [kcl_pkg::LEN_W:0]         shamt;

  // Complement all 32 bases in reversed order; the wanted result sits in the
  // top 2*k bits and is shifted down into place.
  for (genvar i = 0; i < kcl_pkg::MAX_BASES; i++) begin : g_base
    assign rc_full[2*(kcl_pkg::MAX_BASES-1-i) +: 2] = ~word[2*i +: 2];
  end

  always_comb begin
    if (word_length == '0) begin
      bases = kcl_pkg::LEN_W'(1);
    end else if (word_length > kcl_pkg::LEN_W'(kcl_pkg::MAX_BASES)) begin
      bases = kcl_pkg::LEN_W'(kcl_pkg::MAX_BASES);
    end else begin
      bases = word_length;
    end
    unused_bases = kcl_pkg::LEN_W'(kcl_pkg::MAX_BASES) - bases;
    shamt        = {unused_bases, 1'b0};
    rc           = rc_full >> shamt;
  end

endmodule

`default_nettype wire

FILE: design/kcl_store.sv
//------------------------------------------------------------------------------
// kcl_store
// Word and frequency tables: one write port, one registered read port each.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_store #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW          = 12
) (
  input  wire logic              clk,
  input  wire kcl_pkg::kcl_wr_t  wr,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic              rd_en,
  input  wire logic [AW-1:0]     rd_addr,
  output kcl_pkg::kmer_t         rd_word,
  output kcl_pkg::freq_t         rd_freq
);

  kcl_pkg::kmer_t word_mem [TABLE_DEPTH];
  kcl_pkg::freq_t freq_mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      word_mem[wr_addr] <= wr.word;
      freq_mem[wr_addr] <= wr.freq;
    end
    if (rd_en) begin
      rd_word <= word_mem[rd_addr];
      rd_freq <= freq_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/kcl_ctrl.sv
//------------------------------------------------------------------------------
// kcl_ctrl
// Request sequencer: table loads, canonical key selection and binary search.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_ctrl #(
  parameter int TABLE_DEPTH = 4096,
  parameter int AW          = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  kcl_req_if.sink                            req,
  kcl_rsp_if.source                          rsp,
  input  wire logic [kcl_pkg::COUNT_W-1:0]   entry_count,
  output kcl_pkg::kmer_t                     q_word,
  input  wire kcl_pkg::kmer_t                rc,
  output kcl_pkg::kcl_wr_t                   wr,
  output logic [AW-1:0]                      wr_addr,
  output logic                               rd_en,
  output logic [AW-1:0]                      rd_addr,
  input  wire kcl_pkg::kmer_t                rd_word,
  input  wire kcl_pkg::freq_t                rd_freq
);

  localparam int CW  = AW + 1;
  localparam int EW  = (CW > kcl_pkg::COUNT_W) ? CW : kcl_pkg::COUNT_W;
  localparam int IXW = (CW > kcl_pkg::INDEX_W) ? CW : kcl_pkg::INDEX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CANON,
    S_PICK,
    S_ADDR,
    S_CMP,
    S_EMIT
  } state_t;

  state_t         state;
  kcl_pkg::kmer_t key;
  logic [CW-1:0]  low;
  logic [CW-1:0]  high;
  kcl_pkg::freq_t res;
  logic           out_valid;
  kcl_pkg::freq_t out_freq;

  logic           accept;
  logic           in_range;
  logic [EW-1:0]  count_ext;
  logic [EW-1:0]  depth_ext;
  logic [CW-1:0]  n_clamp;
  logic [CW:0]    mid_sum;
  logic [CW-1:0]  mid;
  logic [CW-1:0]  mid_inc;
  logic [CW-1:0]  mid_dec;

  always_comb begin
    accept    = req.valid && req.ready;
    in_range  = IXW'(req.entry_index) < IXW'(TABLE_DEPTH);
    count_ext = EW'(entry_count);
    depth_ext = EW'(TABLE_DEPTH);
    n_clamp   = (count_ext > depth_ext) ? CW'(depth_ext) : CW'(count_ext);
    mid_sum   = {1'b0, low} + {1'b0, high};
    mid       = mid_sum[CW:1];
    mid_inc   = mid + CW'(1);
    mid_dec   = mid - CW'(1);
  end

  assign req.ready     = (state == S_IDLE);
  assign rsp.valid     = out_valid;
  assign rsp.frequency = out_freq;

  assign wr.en   = accept && (req.action == kcl_pkg::ACT_LOAD) && in_range;
  assign wr.word = req.kmer_word;
  assign wr.freq = req.load_frequency;
  assign wr_addr = AW'(req.entry_index);
  assign rd_en   = (state == S_ADDR);
  assign rd_addr = mid[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept && (req.action == kcl_pkg::ACT_LOOKUP)) begin
            q_word <= req.kmer_word;
            state  <= S_CANON;
          end
        end
        S_CANON: begin
          key   <= rc;
          state <= S_PICK;
        end
        S_PICK: begin
          if (q_word < key) begin
            key <= q_word;
          end
          low  <= '0;
          high <= n_clamp - CW'(1);
          if (n_clamp == '0) begin
            res   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_word == key) begin
            res   <= rd_freq;
            state <= S_EMIT;
          end else if (rd_word < key) begin
            low <= mid_inc;
            if (mid_inc > high) begin
              res   <= '0;
              state <= S_EMIT;
            end else begin
              state <= S_ADDR;
            end
          end else begin
            // The probe was too large; the search ends at position zero or once no entry is left below it.
            if ((mid == '0) || (mid_dec < low)) begin
              res   <= '0;
              state <= S_EMIT;
            end else begin
              high  <= mid_dec;
              state <= S_ADDR;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_freq  <= res;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/canonical_kmer_count_lookup.sv
//------------------------------------------------------------------------------
// canonical_kmer_count_lookup
// Sorted k-mer table with canonical-form binary-search frequency lookup.
//------------------------------------------------------------------------------
// A load request writes one word and its frequency into the table in the
// cycle it is accepted and produces no result. A lookup request passes
// through S_CANON and S_PICK, which pick the canonical key, then P probes,
// then S_EMIT, which loads the result into the output register once it is
// free. P is the number of binary-search probes, at most ceil(log2(n + 1))
// for n searched entries (entry_count, capped at the table depth). Each
// probe is split in two because the table is a synchronous memory with a
// registered read: S_ADDR presents the midpoint address and S_CMP compares
// the returned word and moves the search bounds. One lookup is in the search at
// a time; a finished result waits in the output register while the next
// request is taken. Loads and configuration writes are expected only while no
// lookup is in progress.
//------------------------------------------------------------------------------
`default_nettype none

module canonical_kmer_count_lookup #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [kcl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_data,
  kcl_req_if.sink                               req,
  kcl_rsp_if.source                             rsp
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [kcl_pkg::LEN_W-1:0]   word_length;
  logic [kcl_pkg::COUNT_W-1:0] entry_count;

  kcl_pkg::kmer_t   q_word;
  kcl_pkg::kmer_t   rc;
  kcl_pkg::kcl_wr_t wr;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  kcl_pkg::kmer_t   rd_word;
  kcl_pkg::freq_t   rd_freq;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length <= kcl_pkg::WORD_LENGTH_RST;
      entry_count <= kcl_pkg::ENTRY_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        kcl_pkg::REG_WORD_LENGTH: word_length <= cfg_data[kcl_pkg::LEN_W-1:0];
        kcl_pkg::REG_ENTRY_COUNT: entry_count <= cfg_data[kcl_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  kcl_canon u_canon (
    .word        (q_word),
    .word_length (word_length),
    .rc          (rc)
  );

  kcl_store #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .wr      (wr),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_word (rd_word),
    .rd_freq (rd_freq)
  );

  kcl_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .entry_count (entry_count),
    .q_word      (q_word),
    .rc          (rc),
    .wr          (wr),
    .wr_addr     (wr_addr),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_word     (rd_word),
    .rd_freq     (rd_freq)
  );

endmodule

`default_nettype wire

FILE: design/kcl_checker.sv
//------------------------------------------------------------------------------
// kcl_checker
// Port-level checks of the canonical k-mer count lookup, bound to the top.
//------------------------------------------------------------------------------
`default_nettype none

module kcl_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           req_action,
  input wire logic           rsp_valid,
  input wire logic           rsp_ready,
  input wire kcl_pkg::freq_t rsp_frequency
);

  logic       lookup_acc;
  logic       rsp_acc;
  logic [1:0] pending;

  assign lookup_acc = req_valid && req_ready && (req_action == kcl_pkg::ACT_LOOKUP);
  assign rsp_acc    = rsp_valid && rsp_ready;

  // Lookups accepted whose results have not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + {1'b0, lookup_acc} - {1'b0, rsp_acc};
    end
  end

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before it was taken");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_frequency))
    else $error("stalled result changed");

  a_busy_after_lookup: assert property (@(posedge clk) disable iff (rst)
    lookup_acc |=> !req_ready)
    else $error("new request taken while a lookup is searching");

  a_no_spurious_rsp: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 2'd0)
    else $error("result shown with no lookup outstanding");

  a_bounded_pending: assert property (@(posedge clk) disable iff (rst)
    pending == 2'd2 |-> !lookup_acc)
    else $error("third lookup accepted while two are outstanding");

endmodule

bind canonical_kmer_count_lookup kcl_checker u_kcl_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_action    (req.action),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_frequency (rsp.frequency)
);

`default_nettype wire
